FILE: design/tsq_pkg.sv
package tsq_pkg;

   localparam int TSQ_SLOTS        = 8;
   localparam int TSQ_PAYLOAD_BITS = 32;

   localparam int TYPE_BITS  = 8;
   localparam int TIME_BITS  = 32;
   localparam int PORT_BITS  = 32;
   localparam int WIDE_BITS  = 64;

   localparam logic [TIME_BITS-1:0] HALF_RANGE = 32'h8000_0000;

   localparam logic OP_PUT = 1'b0;
   localparam logic OP_GET = 1'b1;

   typedef struct packed {
      logic [TIME_BITS-1:0] diff;
      logic                 less;
      logic                 late;
   } cmp_result_type;

endpackage

FILE: design/tsq_ram.sv
module tsq_ram
   import tsq_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/tsq_cmp.sv
module tsq_cmp
   import tsq_pkg::*;
(
   input  logic [TIME_BITS-1:0] slot_start,
   input  logic [TIME_BITS-1:0] now_time,
   input  logic [TIME_BITS-1:0] best_diff,
   output cmp_result_type       result
);

   logic [TIME_BITS-1:0] diff;

   // The difference wraps modulo the timer range.
   assign diff        = slot_start - now_time;
   assign result.diff = diff;
   assign result.less = (diff < best_diff);
   assign result.late = (diff > HALF_RANGE);

endmodule

FILE: design/timed_receive_slot_queue.sv
// Channel  | Direction | Handshake             | Payload
// req      | in        | req_valid / req_ready | operation, job_type, job_start,
//          |           |                       | job_payload, now_time
// rsp      | out       | rsp_valid / rsp_ready | success, out_type, out_start,
//          |           |                       | out_payload
//
// A put walks the slot-used bits from the first slot, one slot per cycle, until it
// finds a free one or has tried the last slot.
// A get reads each slot from the slot RAM and passes it through the single shared
// subtract and compare unit, one slot per cycle.
// Reset clears every slot-used bit and the control state.
// A held result stalls the sequencer in its last state; no new item is taken meanwhile.
module timed_receive_slot_queue
   import tsq_pkg::*;
#(
   parameter int SLOTS        = TSQ_SLOTS,
   parameter int PAYLOAD_BITS = TSQ_PAYLOAD_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_operation,
   input  logic [TYPE_BITS-1:0] req_job_type,
   input  logic [TIME_BITS-1:0] req_job_start,
   input  logic [PORT_BITS-1:0] req_job_payload,
   input  logic [TIME_BITS-1:0] req_now_time,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_success,
   output logic [TYPE_BITS-1:0] rsp_out_type,
   output logic [TIME_BITS-1:0] rsp_out_start,
   output logic [PORT_BITS-1:0] rsp_out_payload
);

   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int WORD_W = TYPE_BITS + TIME_BITS + PAYLOAD_BITS;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PUT   = 3'd1;
   localparam logic [2:0] S_GET   = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [SLOTS-1:0]        used_ff, used_in;
   logic [IDX_W-1:0]        scan_idx_ff, scan_idx_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic                    pend_used_ff, pend_used_in;
   logic [IDX_W-1:0]        pend_idx_ff, pend_idx_in;
   logic                    op_ff, op_in;
   logic [TYPE_BITS-1:0]    type_ff, type_in;
   logic [TIME_BITS-1:0]    start_ff, start_in;
   logic [PAYLOAD_BITS-1:0] payload_ff, payload_in;
   logic [TIME_BITS-1:0]    now_ff, now_in;
   logic [TIME_BITS-1:0]    best_d_ff, best_d_in;
   logic [IDX_W-1:0]        best_idx_ff, best_idx_in;
   logic                    res_success_ff, res_success_in;
   logic [TYPE_BITS-1:0]    res_type_ff, res_type_in;
   logic [TIME_BITS-1:0]    res_start_ff, res_start_in;
   logic [PAYLOAD_BITS-1:0] res_payload_ff, res_payload_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_success_ff, rsp_success_in;
   logic [TYPE_BITS-1:0]    rsp_type_ff, rsp_type_in;
   logic [TIME_BITS-1:0]    rsp_start_ff, rsp_start_in;
   logic [PORT_BITS-1:0]    rsp_payload_ff, rsp_payload_in;

   logic                    ram_wr_en;
   logic [WORD_W-1:0]       ram_wr_data;
   logic [WORD_W-1:0]       ram_rd_data;
   logic [TYPE_BITS-1:0]    rd_type;
   logic [TIME_BITS-1:0]    rd_start;
   logic [PAYLOAD_BITS-1:0] rd_payload;
   cmp_result_type          cmp;
   logic [WIDE_BITS-1:0]    req_payload_wide;
   logic [WIDE_BITS-1:0]    res_payload_wide;
   logic                    accept;
   logic                    rsp_free;

   assign ram_wr_data = {type_ff, start_ff, payload_ff};
   assign rd_type     = ram_rd_data[WORD_W-1 -: TYPE_BITS];
   assign rd_start    = ram_rd_data[PAYLOAD_BITS +: TIME_BITS];
   assign rd_payload  = ram_rd_data[PAYLOAD_BITS-1:0];

   assign req_payload_wide = {{(WIDE_BITS - PORT_BITS){1'b0}}, req_job_payload};
   assign res_payload_wide = WIDE_BITS'(res_payload_ff);

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   tsq_ram #(
      .WIDTH(WORD_W),
      .DEPTH(SLOTS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(scan_idx_ff),
      .wr_data(ram_wr_data),
      .rd_addr(scan_idx_ff),
      .rd_data(ram_rd_data)
   );

   tsq_cmp u_cmp (
      .slot_start(rd_start),
      .now_time  (now_ff),
      .best_diff (best_d_ff),
      .result    (cmp)
   );

   always_comb begin
      state_in       = state_ff;
      used_in        = used_ff;
      scan_idx_in    = scan_idx_ff;
      pend_valid_in  = 1'b0;
      pend_used_in   = pend_used_ff;
      pend_idx_in    = pend_idx_ff;
      op_in          = op_ff;
      type_in        = type_ff;
      start_in       = start_ff;
      payload_in     = payload_ff;
      now_in         = now_ff;
      best_d_in      = best_d_ff;
      best_idx_in    = best_idx_ff;
      res_success_in = res_success_ff;
      res_type_in    = res_type_ff;
      res_start_in   = res_start_ff;
      res_payload_in = res_payload_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_success_in = rsp_success_ff;
      rsp_type_in    = rsp_type_ff;
      rsp_start_in   = rsp_start_ff;
      rsp_payload_in = rsp_payload_ff;
      ram_wr_en      = 1'b0;

      // Compare stage: RAM data belongs to the slot read in the previous cycle.
      if (pend_valid_ff && pend_used_ff) begin
         if (cmp.less) begin
            best_d_in      = cmp.diff;
            best_idx_in    = pend_idx_ff;
            res_success_in = 1'b1;
            res_type_in    = rd_type;
            res_start_in   = rd_start;
            res_payload_in = rd_payload;
         end
         if (cmp.late) begin
            used_in[pend_idx_ff] = 1'b0;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in          = req_operation;
               type_in        = req_job_type;
               start_in       = req_job_start;
               payload_in     = req_payload_wide[PAYLOAD_BITS-1:0];
               now_in         = req_now_time;
               scan_idx_in    = '0;
               best_d_in      = HALF_RANGE;
               res_success_in = 1'b0;
               res_type_in    = '0;
               res_start_in   = '0;
               res_payload_in = '0;
               state_in       = (req_operation == OP_GET) ? S_GET : S_PUT;
            end
         end
         S_PUT: begin
            if (!used_ff[scan_idx_ff]) begin
               ram_wr_en            = 1'b1;
               used_in[scan_idx_ff] = (type_ff != '0);
               res_success_in       = 1'b1;
               state_in             = S_DONE;
            end else if (scan_idx_ff == LAST_IDX) begin
               state_in = S_DONE;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         S_GET: begin
            pend_valid_in = 1'b1;
            pend_used_in  = used_ff[scan_idx_ff];
            pend_idx_in   = scan_idx_ff;
            if (scan_idx_ff == LAST_IDX) begin
               state_in = S_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_success_in = res_success_ff;
               rsp_type_in    = res_type_ff;
               rsp_start_in   = res_start_ff;
               rsp_payload_in = res_payload_wide[PORT_BITS-1:0];
               if (op_ff == OP_GET && res_success_ff) begin
                  used_in[best_idx_ff] = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      scan_idx_ff    <= scan_idx_in;
      pend_used_ff   <= pend_used_in;
      pend_idx_ff    <= pend_idx_in;
      op_ff          <= op_in;
      type_ff        <= type_in;
      start_ff       <= start_in;
      payload_ff     <= payload_in;
      now_ff         <= now_in;
      best_d_ff      <= best_d_in;
      best_idx_ff    <= best_idx_in;
      res_success_ff <= res_success_in;
      res_type_ff    <= res_type_in;
      res_start_ff   <= res_start_in;
      res_payload_ff <= res_payload_in;
      rsp_success_ff <= rsp_success_in;
      rsp_type_ff    <= rsp_type_in;
      rsp_start_ff   <= rsp_start_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_success     = rsp_success_ff;
   assign rsp_out_type    = rsp_type_ff;
   assign rsp_out_start   = rsp_start_ff;
   assign rsp_out_payload = rsp_payload_ff;

   // A returned job always lies strictly inside the near half of the timer range.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && op_ff == OP_GET && res_success_ff) |->
         (best_d_ff < HALF_RANGE))
      else $error("returned job is not within half range");

   // A delivered get frees the slot it returned.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_free && op_ff == OP_GET && res_success_ff) |=>
         !used_ff[$past(best_idx_ff)])
      else $error("returned slot still marked used");

   // A put of a nonzero type into a free slot marks that slot used.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUT && !used_ff[scan_idx_ff] && type_ff != '0) |=>
         used_ff[$past(scan_idx_ff)])
      else $error("put did not claim the free slot");

   // A result appears only when the sequencer finishes an item.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("result raised outside the final state");

endmodule
